@@ rtl/tlik_pkg.sv @@
// Shared widths, constants, types and the arctangent table of the
// two-link inverse kinematics pipeline. No dependencies.
`default_nettype none

package tlik_pkg;

   // Field widths
   localparam int XW   = 16;   // target coordinate
   localparam int LW   = 14;   // link length
   localparam int LIMW = 15;   // joint limit
   localparam int OW   = 16;   // output angle
   localparam int IW   = 2;    // csr index
   localparam int DW   = 15;   // csr data

   // Register indexes
   localparam logic [IW-1:0] REG_INNER    = 2'd0;
   localparam logic [IW-1:0] REG_OUTER    = 2'd1;
   localparam logic [IW-1:0] REG_SHOULDER = 2'd2;
   localparam logic [IW-1:0] REG_ELBOW    = 2'd3;

   // Register reset values
   localparam logic [LW-1:0]   INNER_RESET    = 14'd5600;
   localparam logic [LW-1:0]   OUTER_RESET    = 14'd4000;
   localparam logic [LIMW-1:0] SHOULDER_RESET = 15'd19200;
   localparam logic [LIMW-1:0] ELBOW_RESET    = 15'd21760;

   // Parameter defaults
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_FRAC_DEF   = 7;
   localparam int ATAN_LEN         = 24;

   // Datapath widths
   localparam int SQW      = 60;        // radicand (hi^2 - r2) * (r2 - lo^2)
   localparam int SRW      = 30;        // square root
   localparam int SQ_STEPS = SQW / 2;   // one root bit per stage
   localparam int CIW      = 33;        // CORDIC operand
   localparam int PRE_SH   = 24;        // operand prescale
   localparam int CW       = CIW + PRE_SH + 2;
   localparam int ZW       = 34;        // CORDIC binary angle
   localparam int ATW      = 30;        // table entry
   localparam int AW       = 35;        // combined angle
   localparam int KW       = 20;        // degree scale factor
   localparam int PW       = AW + KW;   // scaled angle
   localparam int UW       = PW - 31;   // rounded angle magnitude

   localparam logic signed [ZW-1:0] Z_HALF = 34'sh0_8000_0000;
   localparam logic signed [AW-1:0] A_HALF = 35'sh0_8000_0000;
   localparam logic signed [AW-1:0] A_FULL = 35'sh1_0000_0000;
   localparam logic [PW:0]          ROUND_HALF = (PW+1)'(33'h0_8000_0000);

   typedef struct packed {
      logic                  valid;
      logic                  sel;
      logic                  oor;
      logic signed [CIW-1:0] n;
      logic signed [CIW-1:0] m;
      logic signed [XW-1:0]  x;
      logic signed [XW-1:0]  y;
   } side_type;

   typedef struct packed {
      logic valid;
      logic sel;
      logic oor;
   } ctl_type;

   // atan(2^-i) in binary angle units, full turn = 2^32
   function automatic logic [ATW-1:0] atan_turn(input int unsigned i);
      logic [ATW-1:0] v;
      case (i)
         0:  v = 30'd536870912;
         1:  v = 30'd316933406;
         2:  v = 30'd167458907;
         3:  v = 30'd85004756;
         4:  v = 30'd42667331;
         5:  v = 30'd21354465;
         6:  v = 30'd10679838;
         7:  v = 30'd5340245;
         8:  v = 30'd2670163;
         9:  v = 30'd1335087;
         10: v = 30'd667544;
         11: v = 30'd333772;
         12: v = 30'd166886;
         13: v = 30'd83443;
         14: v = 30'd41722;
         15: v = 30'd20861;
         16: v = 30'd10430;
         17: v = 30'd5215;
         18: v = 30'd2608;
         19: v = 30'd1304;
         20: v = 30'd652;
         21: v = 30'd326;
         22: v = 30'd163;
         23: v = 30'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/tlik_channels.sv @@
// Request and response channel interfaces (valid/ready plus payload).
// Depends on tlik_pkg.
`default_nettype none

interface tlik_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [tlik_pkg::XW-1:0] target_x;
   logic signed [tlik_pkg::XW-1:0] target_y;
   logic                           elbow_select;

   modport source (output valid, target_x, target_y, elbow_select, input ready);
   modport sink   (input valid, target_x, target_y, elbow_select, output ready);
endinterface

interface tlik_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [tlik_pkg::OW-1:0] shoulder_angle;
   logic signed [tlik_pkg::OW-1:0] elbow_angle;
   logic                           out_of_reach;
   logic                           beyond_joint_limit;

   modport source (output valid, shoulder_angle, elbow_angle, out_of_reach,
                   beyond_joint_limit, input ready);
   modport sink   (input valid, shoulder_angle, elbow_angle, out_of_reach,
                   beyond_joint_limit, output ready);
endinterface

`default_nettype wire

@@ rtl/two_link_inverse_kinematics.sv @@
// Top level of the two-link planar inverse kinematics pipeline.
// Depends on tlik_pkg, tlik_channels, tlik_sqrt_pipe, tlik_cordic_pipe.
//
// Usage:
//  - req_if carries a target (x, y, 4 fraction bits) and an elbow selector;
//    rsp_if returns shoulder and elbow angles in 1/2^ANGLE_FRAC_BITS degree,
//    an out-of-reach flag (angles then 0) and a joint-limit flag.
//  - csr_we/csr_index/csr_wdata write link lengths and joint limits; write
//    only while no request is in flight.
//  - Throughput: one request per cycle while rsp_if is not stalled. A request
//    passes S0 to S4, the 30-stage square-root pipe and the CORDIC stages, then
//    the combine, scale and response registers before rsp_if.valid.
//  - The whole pipeline advances on one enable: when the response register
//    holds a request the receiver does not take, every stage holds and
//    req_if.ready drops; nothing is dropped or repeated.
//  - Synchronous reset clears all valid bits and restores register defaults.
//  - Reach uses the identity 4*r2*L1^2 - n^2 = (hi^2 - r2)(r2 - lo^2), which
//    is also the elbow radicand, so one root feeds both cosine-law atan2s.
`default_nettype none

module two_link_inverse_kinematics #(
   parameter int CORDIC_STEPS    = tlik_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   tlik_req_if.sink                       req_if,
   tlik_rsp_if.source                     rsp_if,
   input  wire logic                      csr_we,
   input  wire logic [tlik_pkg::IW-1:0]   csr_index,
   input  wire logic [tlik_pkg::DW-1:0]   csr_wdata
);

   localparam int XW   = tlik_pkg::XW;
   localparam int LW   = tlik_pkg::LW;
   localparam int LIMW = tlik_pkg::LIMW;
   localparam int CIW  = tlik_pkg::CIW;
   localparam int ZW   = tlik_pkg::ZW;
   localparam int AW   = tlik_pkg::AW;
   localparam int KW   = tlik_pkg::KW;
   localparam int PW   = tlik_pkg::PW;
   localparam int UW   = tlik_pkg::UW;
   localparam int OW   = tlik_pkg::OW;
   localparam int SQN  = tlik_pkg::SQ_STEPS;
   localparam logic signed [KW-1:0] UNIT_SCALE = KW'(360 * (1 << ANGLE_FRAC_BITS));

   // ---------------- configuration registers
   logic [LW-1:0]   inner_ff, outer_ff;
   logic [LIMW-1:0] shoulder_lim_ff, elbow_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff        <= tlik_pkg::INNER_RESET;
         outer_ff        <= tlik_pkg::OUTER_RESET;
         shoulder_lim_ff <= tlik_pkg::SHOULDER_RESET;
         elbow_lim_ff    <= tlik_pkg::ELBOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tlik_pkg::REG_INNER:    inner_ff        <= csr_wdata[LW-1:0];
            tlik_pkg::REG_OUTER:    outer_ff        <= csr_wdata[LW-1:0];
            tlik_pkg::REG_SHOULDER: shoulder_lim_ff <= csr_wdata;
            tlik_pkg::REG_ELBOW:    elbow_lim_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- global advance
   logic out_valid_ff, adv;
   assign adv          = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;

   // ---------------- S0: request capture
   logic                 s0_valid_ff, s0_sel_ff;
   logic signed [XW-1:0] s0_x_ff, s0_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_x_ff   <= req_if.target_x;
         s0_y_ff   <= req_if.target_y;
         s0_sel_ff <= req_if.elbow_select;
      end
   end

   // ---------------- S1: squares
   logic                 s1_valid_ff, s1_sel_ff, s1_l1zero_ff;
   logic signed [XW-1:0] s1_x_ff, s1_y_ff;
   logic [31:0]          s1_xx_ff, s1_yy_ff;
   logic [2*LW-1:0]      s1_l1sq_ff, s1_l2sq_ff, s1_losq_ff;
   logic [2*LW+1:0]      s1_hisq_ff;
   logic signed [2*XW-1:0] xx_in, yy_in;
   logic [LW:0]          hi_in;
   logic [LW-1:0]        lo_in;

   assign xx_in = s0_x_ff * s0_x_ff;
   assign yy_in = s0_y_ff * s0_y_ff;
   assign hi_in = {1'b0, inner_ff} + {1'b0, outer_ff};
   assign lo_in = (inner_ff >= outer_ff) ? inner_ff - outer_ff : outer_ff - inner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sel_ff    <= s0_sel_ff;
         s1_x_ff      <= s0_x_ff;
         s1_y_ff      <= s0_y_ff;
         s1_xx_ff     <= $unsigned(xx_in);
         s1_yy_ff     <= $unsigned(yy_in);
         s1_l1sq_ff   <= inner_ff * inner_ff;
         s1_l2sq_ff   <= outer_ff * outer_ff;
         s1_hisq_ff   <= hi_in * hi_in;
         s1_losq_ff   <= lo_in * lo_in;
         s1_l1zero_ff <= (inner_ff == '0);
      end
   end

   // ---------------- S2: r2 = x^2 + y^2
   logic                 s2_valid_ff, s2_sel_ff, s2_l1zero_ff;
   logic signed [XW-1:0] s2_x_ff, s2_y_ff;
   logic [31:0]          s2_r2_ff;
   logic [2*LW-1:0]      s2_l1sq_ff, s2_l2sq_ff, s2_losq_ff;
   logic [2*LW+1:0]      s2_hisq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sel_ff    <= s1_sel_ff;
         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
         s2_r2_ff     <= s1_xx_ff + s1_yy_ff;
         s2_l1sq_ff   <= s1_l1sq_ff;
         s2_l2sq_ff   <= s1_l2sq_ff;
         s2_losq_ff   <= s1_losq_ff;
         s2_hisq_ff   <= s1_hisq_ff;
         s2_l1zero_ff <= s1_l1zero_ff;
      end
   end

   // ---------------- S3: reach check, cosine-law numerators, root factors
   tlik_pkg::side_type s3_side_ff, s3_side_in;
   logic [29:0]        s3_da_ff, s3_db_ff;
   logic [31:0]        da_full, db_full;
   logic [CIW-1:0]     n_raw, m_raw;

   always_comb begin
      da_full = 32'(s2_hisq_ff) - s2_r2_ff;
      db_full = s2_r2_ff - 32'(s2_losq_ff);
      n_raw   = CIW'(s2_r2_ff) + CIW'(s2_l1sq_ff) - CIW'(s2_l2sq_ff);
      m_raw   = CIW'(s2_r2_ff) - CIW'(s2_l1sq_ff) - CIW'(s2_l2sq_ff);
      s3_side_in.valid = s2_valid_ff;
      s3_side_in.sel   = s2_sel_ff;
      s3_side_in.oor   = (s2_r2_ff == '0) || s2_l1zero_ff ||
                         (s2_r2_ff < 32'(s2_losq_ff)) || (s2_r2_ff > 32'(s2_hisq_ff));
      s3_side_in.n     = $signed(n_raw);
      s3_side_in.m     = $signed(m_raw);
      s3_side_in.x     = s2_x_ff;
      s3_side_in.y     = s2_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff.valid <= 1'b0;
      end else if (adv) begin
         s3_side_ff <= s3_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_da_ff <= da_full[29:0];
         s3_db_ff <= db_full[29:0];
      end
   end

   // ---------------- S4: radicand, then delay line beside the root pipe
   tlik_pkg::side_type side_ff [0:SQN];
   logic [tlik_pkg::SQW-1:0] rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].valid <= 1'b0;
      end else if (adv) begin
         side_ff[0] <= s3_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff <= s3_da_ff * s3_db_ff;
      end
   end

   for (genvar k = 1; k <= SQN; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else if (adv) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   logic [tlik_pkg::SRW-1:0] root;

   tlik_sqrt_pipe u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (rad_ff),
      .root     (root)
   );

   // ---------------- three CORDIC lanes: alpha, gamma, bearing
   logic signed [CIW-1:0] root_ext, bx_ext, by_ext;
   logic signed [ZW-1:0]  alpha, gamma, beta;

   assign root_ext = $signed(CIW'(root));
   assign bx_ext   = CIW'(side_ff[SQN].x);
   assign by_ext   = CIW'(side_ff[SQN].y);

   tlik_cordic_pipe #(.STEPS(CORDIC_STEPS)) u_alpha (
      .clock (clock), .en (adv), .y_in (root_ext), .x_in (side_ff[SQN].n), .angle (alpha)
   );

   tlik_cordic_pipe #(.STEPS(CORDIC_STEPS)) u_gamma (
      .clock (clock), .en (adv), .y_in (root_ext), .x_in (side_ff[SQN].m), .angle (gamma)
   );

   tlik_cordic_pipe #(.STEPS(CORDIC_STEPS)) u_beta (
      .clock (clock), .en (adv), .y_in (by_ext), .x_in (bx_ext), .angle (beta)
   );

   tlik_pkg::ctl_type ctl_ff [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else if (adv) begin
         ctl_ff[0].valid <= side_ff[SQN].valid;
         ctl_ff[0].sel   <= side_ff[SQN].sel;
         ctl_ff[0].oor   <= side_ff[SQN].oor;
      end
   end

   for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // ---------------- combine and wrap into +-half turn
   tlik_pkg::ctl_type     cmb_ctl_ff;
   logic signed [AW-1:0]  a1_ff, a2_ff;
   logic signed [AW-1:0]  a1_raw, a2_raw, a1_in, a2_in;

   always_comb begin
      a1_raw = ctl_ff[CORDIC_STEPS].sel ? AW'(beta) - AW'(alpha) : AW'(beta) + AW'(alpha);
      a2_raw = ctl_ff[CORDIC_STEPS].sel ? AW'(gamma) : -AW'(gamma);
      if (a1_raw > tlik_pkg::A_HALF)       a1_in = a1_raw - tlik_pkg::A_FULL;
      else if (a1_raw < -tlik_pkg::A_HALF) a1_in = a1_raw + tlik_pkg::A_FULL;
      else                                 a1_in = a1_raw;
      if (a2_raw > tlik_pkg::A_HALF)       a2_in = a2_raw - tlik_pkg::A_FULL;
      else if (a2_raw < -tlik_pkg::A_HALF) a2_in = a2_raw + tlik_pkg::A_FULL;
      else                                 a2_in = a2_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmb_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         cmb_ctl_ff <= ctl_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff <= a1_in;
         a2_ff <= a2_in;
      end
   end

   // ---------------- scale to degree units
   tlik_pkg::ctl_type    mul_ctl_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         mul_ctl_ff <= cmb_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= PW'(a1_ff) * PW'(UNIT_SCALE);
         p2_ff <= PW'(a2_ff) * PW'(UNIT_SCALE);
      end
   end

   // ---------------- round half away from zero, limit check, response register
   logic [PW-1:0] mag1, mag2;
   logic [PW:0]   sum1, sum2;
   logic [UW-1:0] q1, q2, u1, u2;
   logic          lim_in;

   always_comb begin
      mag1   = p1_ff[PW-1] ? $unsigned(-p1_ff) : $unsigned(p1_ff);
      mag2   = p2_ff[PW-1] ? $unsigned(-p2_ff) : $unsigned(p2_ff);
      sum1   = {1'b0, mag1} + tlik_pkg::ROUND_HALF;
      sum2   = {1'b0, mag2} + tlik_pkg::ROUND_HALF;
      q1     = sum1[PW:32];
      q2     = sum2[PW:32];
      u1     = p1_ff[PW-1] ? -q1 : q1;
      u2     = p2_ff[PW-1] ? -q2 : q2;
      lim_in = (q1 > UW'(shoulder_lim_ff)) || (q2 > UW'(elbow_lim_ff));
   end

   logic signed [OW-1:0] shoulder_ff, elbow_ff;
   logic                 oor_ff, lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= mul_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oor_ff      <= mul_ctl_ff.oor;
         shoulder_ff <= mul_ctl_ff.oor ? '0 : $signed(u1[OW-1:0]);
         elbow_ff    <= mul_ctl_ff.oor ? '0 : $signed(u2[OW-1:0]);
         lim_ff      <= !mul_ctl_ff.oor && lim_in;
      end
   end

   assign rsp_if.valid              = out_valid_ff;
   assign rsp_if.shoulder_angle     = shoulder_ff;
   assign rsp_if.elbow_angle        = elbow_ff;
   assign rsp_if.out_of_reach       = oor_ff;
   assign rsp_if.beyond_joint_limit = lim_ff;

endmodule

`default_nettype wire

@@ rtl/tlik_sqrt_pipe.sv @@
// Pipelined floor integer square root, one root bit per stage.
// Depends on tlik_pkg.
`default_nettype none

module tlik_sqrt_pipe (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [tlik_pkg::SQW-1:0]     radicand,
   output logic      [tlik_pkg::SRW-1:0]     root
);

   localparam int W = tlik_pkg::SQW;
   localparam int N = tlik_pkg::SQ_STEPS;

   logic [W-1:0] rem_ff [1:N-1];
   logic [W-1:0] res_ff [1:N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2*j);
      logic [W-1:0] rem_cur, res_cur, rem_in, res_in;
      logic [W:0]   trial;

      if (j == 0) begin : g_first
         assign rem_cur = radicand;
         assign res_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[j];
         assign res_cur = res_ff[j];
      end

      always_comb begin
         trial = {1'b0, res_cur} + {1'b0, BIT};
         if ({1'b0, rem_cur} >= trial) begin
            rem_in = rem_cur - W'(trial);
            res_in = (res_cur >> 1) + BIT;
         end else begin
            rem_in = rem_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[j+1] <= res_in;
         end
      end

      if (j < N - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j+1] <= rem_in;
            end
         end
      end
   end

   assign root = res_ff[N][tlik_pkg::SRW-1:0];

endmodule

`default_nettype wire

@@ rtl/tlik_cordic_pipe.sv @@
// Pipelined vectoring CORDIC: binary angle of (x, y), one
// micro-rotation per stage after a prescale/half-plane stage. Depends on tlik_pkg.
`default_nettype none

module tlik_cordic_pipe #(
   parameter int STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic signed [tlik_pkg::CIW-1:0] y_in,
   input  wire logic signed [tlik_pkg::CIW-1:0] x_in,
   output logic signed      [tlik_pkg::ZW-1:0]  angle
);

   localparam int CW = tlik_pkg::CW;
   localparam int ZW = tlik_pkg::ZW;

   logic signed [CW-1:0] x_ff    [0:STEPS];
   logic signed [CW-1:0] y_ff    [0:STEPS];
   logic signed [ZW-1:0] z_ff    [0:STEPS];
   logic                 zero_ff [0:STEPS];

   logic signed [CW-1:0] xs, ys, x0_in, y0_in;
   logic signed [ZW-1:0] z0_in;

   // prescale, fold left half-plane onto the right
   always_comb begin
      xs = CW'(x_in) <<< tlik_pkg::PRE_SH;
      ys = CW'(y_in) <<< tlik_pkg::PRE_SH;
      if (xs[CW-1]) begin
         x0_in = -xs;
         y0_in = -ys;
         z0_in = ys[CW-1] ? -tlik_pkg::Z_HALF : tlik_pkg::Z_HALF;
      end else begin
         x0_in = xs;
         y0_in = ys;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      localparam logic signed [ZW-1:0] ANG =
         $signed({{(ZW-tlik_pkg::ATW){1'b0}}, tlik_pkg::atan_turn(i)});
      logic signed [CW-1:0] dx, dy;
      logic                 up;

      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;
      assign up = !y_ff[i][CW-1] && (y_ff[i] != '0);

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (up) begin
               x_ff[i+1] <= x_ff[i] + dy;
               y_ff[i+1] <= y_ff[i] - dx;
               z_ff[i+1] <= z_ff[i] + ANG;
            end else begin
               x_ff[i+1] <= x_ff[i] - dy;
               y_ff[i+1] <= y_ff[i] + dx;
               z_ff[i+1] <= z_ff[i] - ANG;
            end
         end
      end
   end

   // zero vector reads as angle 0
   assign angle = zero_ff[STEPS] ? '0 : z_ff[STEPS];

endmodule

`default_nettype wire

@@ rtl/tlik_checker.sv @@
// Port-level checks of the inverse kinematics block, bound to its top level.
// Depends on tlik_pkg and two_link_inverse_kinematics.
`default_nettype none

module tlik_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [tlik_pkg::OW-1:0] shoulder_angle,
   input wire logic signed [tlik_pkg::OW-1:0] elbow_angle,
   input wire logic                           out_of_reach,
   input wire logic                           beyond_joint_limit
);

   // flagged target: zero angles, no limit flag
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_of_reach) |->
         (shoulder_angle == '0) && (elbow_angle == '0) && !beyond_joint_limit)
      else $error("out-of-reach response carries nonzero angles or limit flag");

   // a taken response always frees the pipeline entrance
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side stalled while response side is ready");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         rsp_valid && $stable(shoulder_angle) && $stable(elbow_angle) &&
         $stable(out_of_reach) && $stable(beyond_joint_limit))
      else $error("stalled response changed");

endmodule

bind two_link_inverse_kinematics tlik_checker u_tlik_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .shoulder_angle     (rsp_if.shoulder_angle),
   .elbow_angle        (rsp_if.elbow_angle),
   .out_of_reach       (rsp_if.out_of_reach),
   .beyond_joint_limit (rsp_if.beyond_joint_limit)
);

`default_nettype wire
